/* src/tle_pkg.sv */
package tle_pkg;

  // Word format: signed fixed point, 48 bits
  localparam int W = 48;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] pixel_re;
    logic [W-1:0] pixel_im;
    logic [15:0]  iteration_limit;
  } tle_in_t;

  typedef struct packed {
    logic [15:0] iteration_count;
    logic        reached_limit;
    logic        lower_side;
  } tle_out_t;

  // Configuration register indexes
  localparam logic [3:0] CFG_FPRE  = 4'd0;
  localparam logic [3:0] CFG_FPIM  = 4'd1;
  localparam logic [3:0] CFG_PHASE = 4'd2;
  localparam logic [3:0] CFG_EPS   = 4'd3;
  localparam logic [3:0] CFG_ESC   = 4'd4;
  localparam logic [3:0] CFG_EN    = 4'd5;
  localparam logic [3:0] CFG_OMRE  = 4'd6;
  localparam logic [3:0] CFG_OMIM  = 4'd7;

  typedef enum logic [3:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DBL, OP_NEG, OP_TRC, OP_NRC,
    OP_BLIM, OP_BGE, OP_BDIS, OP_INC, OP_DONE
  } tle_op_t;

  // Operand addresses: working registers below 16, live sources from 16 up
  localparam logic [4:0] R_CRE   = 5'd0;
  localparam logic [4:0] R_CIM   = 5'd1;
  localparam logic [4:0] R_A2RE  = 5'd2;
  localparam logic [4:0] R_A2IM  = 5'd3;
  localparam logic [4:0] R_EPS2  = 5'd4;
  localparam logic [4:0] R_XRE   = 5'd5;
  localparam logic [4:0] R_XIM   = 5'd6;
  localparam logic [4:0] R_T0    = 5'd7;
  localparam logic [4:0] R_T1    = 5'd8;
  localparam logic [4:0] R_T2    = 5'd9;
  localparam logic [4:0] R_T3    = 5'd10;
  localparam logic [4:0] R_WRE   = 5'd11;
  localparam logic [4:0] R_WIM   = 5'd12;
  localparam logic [4:0] S_PRE   = 5'd16;
  localparam logic [4:0] S_PIM   = 5'd17;
  localparam logic [4:0] S_PHASE = 5'd18;
  localparam logic [4:0] S_EPS   = 5'd19;
  localparam logic [4:0] S_ESC   = 5'd20;
  localparam logic [4:0] S_OMRE  = 5'd21;
  localparam logic [4:0] S_OMIM  = 5'd22;
  localparam logic [4:0] S_ZRE   = 5'd23;
  localparam logic [4:0] S_ZIM   = 5'd24;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] L_LOOP = 7'd26;
  localparam logic [PC_W-1:0] L_INC  = 7'd68;
  localparam logic [PC_W-1:0] L_END  = 7'd69;
  localparam logic [PC_W-1:0] L_NONE = 7'd0;

  typedef struct packed {
    tle_op_t         op;
    logic [4:0]      dst;
    logic [4:0]      ra;
    logic [4:0]      rb;
    logic [PC_W-1:0] tgt;
  } tle_instr_t;

  function automatic tle_instr_t mk(input tle_op_t op, input logic [4:0] dst,
                                    input logic [4:0] ra, input logic [4:0] rb,
                                    input logic [PC_W-1:0] tgt);
    tle_instr_t r;
    r.op = op;
    r.dst = dst;
    r.ra = ra;
    r.rb = rb;
    r.tgt = tgt;
    return r;
  endfunction

  // Microprogram: setup, map pixel, iterate, optional transit map, side test
  function automatic tle_instr_t rom(input logic [PC_W-1:0] a);
    tle_instr_t r;
    r = mk(OP_DONE, R_T0, R_T0, R_T0, L_NONE);
    case (a)
      7'd0:  r = mk(OP_MUL, R_T0, S_PRE, S_PRE, L_NONE);
      7'd1:  r = mk(OP_MUL, R_T1, S_PIM, S_PIM, L_NONE);
      7'd2:  r = mk(OP_SUB, R_T2, R_T0, R_T1, L_NONE);
      7'd3:  r = mk(OP_MUL, R_T0, S_PRE, S_PIM, L_NONE);
      7'd4:  r = mk(OP_MUL, R_T1, S_PIM, S_PRE, L_NONE);
      7'd5:  r = mk(OP_ADD, R_T3, R_T0, R_T1, L_NONE);
      7'd6:  r = mk(OP_SUB, R_CRE, S_PRE, R_T2, L_NONE);
      7'd7:  r = mk(OP_ADD, R_CIM, S_PIM, R_T3, L_NONE);
      7'd8:  r = mk(OP_DBL, R_T0, R_T2, R_T2, L_NONE);
      7'd9:  r = mk(OP_DBL, R_T0, R_T0, R_T0, L_NONE);
      7'd10: r = mk(OP_DBL, R_T1, S_PRE, S_PRE, L_NONE);
      7'd11: r = mk(OP_ADD, R_A2RE, R_T0, R_T1, L_NONE);
      7'd12: r = mk(OP_DBL, R_T0, R_T3, R_T3, L_NONE);
      7'd13: r = mk(OP_DBL, R_T0, R_T0, R_T0, L_NONE);
      7'd14: r = mk(OP_DBL, R_T1, S_PIM, S_PIM, L_NONE);
      7'd15: r = mk(OP_SUB, R_A2IM, R_T0, R_T1, L_NONE);
      7'd16: r = mk(OP_MUL, R_EPS2, S_EPS, S_EPS, L_NONE);
      7'd17: r = mk(OP_MUL, R_T0, R_A2RE, S_ZRE, L_NONE);
      7'd18: r = mk(OP_MUL, R_T1, R_A2IM, S_ZIM, L_NONE);
      7'd19: r = mk(OP_SUB, R_WRE, R_T0, R_T1, L_NONE);
      7'd20: r = mk(OP_MUL, R_T0, R_A2RE, S_ZIM, L_NONE);
      7'd21: r = mk(OP_MUL, R_T1, R_A2IM, S_ZRE, L_NONE);
      7'd22: r = mk(OP_ADD, R_WIM, R_T0, R_T1, L_NONE);
      7'd23: r = mk(OP_NRC, R_XRE, R_WRE, R_WIM, L_NONE);
      7'd24: r = mk(OP_ADD, R_XRE, R_XRE, S_PRE, L_NONE);
      7'd25: r = mk(OP_ADD, R_XIM, R_XIM, S_PIM, L_NONE);
      7'd26: r = mk(OP_BLIM, R_T0, R_T0, R_T0, L_END);
      7'd27: r = mk(OP_MUL, R_T0, R_XRE, R_XRE, L_NONE);
      7'd28: r = mk(OP_MUL, R_T1, R_XIM, R_XIM, L_NONE);
      7'd29: r = mk(OP_ADD, R_T0, R_T0, R_T1, L_NONE);
      7'd30: r = mk(OP_BGE, R_T0, R_T0, S_ESC, L_END);
      7'd31: r = mk(OP_NEG, R_T3, R_XIM, R_XIM, L_NONE);
      7'd32: r = mk(OP_MUL, R_T0, R_XRE, R_XRE, L_NONE);
      7'd33: r = mk(OP_MUL, R_T1, R_T3, R_T3, L_NONE);
      7'd34: r = mk(OP_SUB, R_T2, R_T0, R_T1, L_NONE);
      7'd35: r = mk(OP_MUL, R_T0, R_XRE, R_T3, L_NONE);
      7'd36: r = mk(OP_MUL, R_T1, R_T3, R_XRE, L_NONE);
      7'd37: r = mk(OP_ADD, R_T1, R_T0, R_T1, L_NONE);
      7'd38: r = mk(OP_ADD, R_XRE, R_T2, R_CRE, L_NONE);
      7'd39: r = mk(OP_ADD, R_XIM, R_T1, R_CIM, L_NONE);
      7'd40: r = mk(OP_BDIS, R_T0, R_T0, R_T0, L_INC);
      7'd41: r = mk(OP_SUB, R_T0, R_XRE, S_PRE, L_NONE);
      7'd42: r = mk(OP_SUB, R_T1, R_XIM, S_PIM, L_NONE);
      7'd43: r = mk(OP_MUL, R_T2, R_A2RE, R_T0, L_NONE);
      7'd44: r = mk(OP_MUL, R_T3, R_A2IM, R_T1, L_NONE);
      7'd45: r = mk(OP_SUB, R_WRE, R_T2, R_T3, L_NONE);
      7'd46: r = mk(OP_MUL, R_T2, R_A2RE, R_T1, L_NONE);
      7'd47: r = mk(OP_MUL, R_T3, R_A2IM, R_T0, L_NONE);
      7'd48: r = mk(OP_ADD, R_WIM, R_T2, R_T3, L_NONE);
      7'd49: r = mk(OP_ADD, R_T2, R_WRE, S_EPS, L_NONE);
      7'd50: r = mk(OP_MUL, R_T2, R_T2, R_T2, L_NONE);
      7'd51: r = mk(OP_MUL, R_T3, R_WIM, R_WIM, L_NONE);
      7'd52: r = mk(OP_ADD, R_T2, R_T2, R_T3, L_NONE);
      7'd53: r = mk(OP_BGE, R_T2, R_T2, R_EPS2, L_INC);
      7'd54: r = mk(OP_NRC, R_WRE, R_WRE, R_WIM, L_NONE);
      7'd55: r = mk(OP_TRC, R_T0, R_WRE, R_WRE, L_NONE);
      7'd56: r = mk(OP_SUB, R_T1, R_WRE, R_T0, L_NONE);
      7'd57: r = mk(OP_SUB, R_T1, R_T1, R_T0, L_NONE);
      7'd58: r = mk(OP_ADD, R_WRE, R_T1, S_PHASE, L_NONE);
      7'd59: r = mk(OP_MUL, R_T0, R_A2RE, R_WRE, L_NONE);
      7'd60: r = mk(OP_MUL, R_T1, R_A2IM, R_WIM, L_NONE);
      7'd61: r = mk(OP_SUB, R_T2, R_T0, R_T1, L_NONE);
      7'd62: r = mk(OP_MUL, R_T0, R_A2RE, R_WIM, L_NONE);
      7'd63: r = mk(OP_MUL, R_T1, R_A2IM, R_WRE, L_NONE);
      7'd64: r = mk(OP_ADD, R_T3, R_T0, R_T1, L_NONE);
      7'd65: r = mk(OP_NRC, R_XRE, R_T2, R_T3, L_NONE);
      7'd66: r = mk(OP_ADD, R_XRE, R_XRE, S_PRE, L_NONE);
      7'd67: r = mk(OP_ADD, R_XIM, R_XIM, S_PIM, L_NONE);
      7'd68: r = mk(OP_INC, R_T0, R_T0, R_T0, L_LOOP);
      7'd69: r = mk(OP_MUL, R_T0, S_OMRE, R_XIM, L_NONE);
      7'd70: r = mk(OP_MUL, R_T1, S_OMIM, R_XRE, L_NONE);
      7'd71: r = mk(OP_ADD, R_T0, R_T0, R_T1, L_NONE);
      default: r = mk(OP_DONE, R_T0, R_T0, R_T0, L_NONE);
    endcase
    return r;
  endfunction

  function automatic logic [W-1:0] sat49(input logic [W:0] v);
    if (v[W] != v[W-1]) return v[W] ? WMIN : WMAX;
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Signed value from a magnitude with an overflow flag, saturated
  function automatic logic [W-1:0] from_mag(input logic ovf, input logic [W-1:0] m,
                                            input logic neg);
    if (neg) begin
      if (ovf || (m[W-1] && |m[W-2:0])) return WMIN;
      return ~m + 1'b1;
    end
    if (ovf || m[W-1]) return WMAX;
    return m;
  endfunction

endpackage

/* src/tle_if.sv */
interface tle_pixel_if;
  logic             valid;
  logic             ready;
  tle_pkg::tle_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tle_result_if;
  logic              valid;
  logic              ready;
  tle_pkg::tle_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/tricorn_lavaurs_escape_time_core.sv */
// Channel   Dir  Payload
// pixel     in   pixel_re, pixel_im, iteration_limit
// result    out  iteration_count, reached_limit, lower_side
// cfg       in   cfg_we, cfg_index, cfg_data (write only)
//
// One pixel at a time through a microcoded sequencer over one 24x24 multiplier
// (4 partial products per multiply) and one bit-serial divider.
// Reset (rst, synchronous) clears the sequencer and loads register defaults.
// A finished result waits in the output register; the next pixel is taken
// meanwhile, and only the final step stalls while that register is full.
module tricorn_lavaurs_escape_time_core #(
  parameter int FRAC_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  tle_pixel_if.sink          pixel,
  tle_result_if.source       result,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [tle_pkg::W-1:0] cfg_data
);

  localparam int W = tle_pkg::W;
  localparam int PW = tle_pkg::PW;
  localparam int NW = W + 2 * FRAC_BITS;
  localparam int DC_W = $clog2(NW);
  localparam logic [W-1:0] FMASK = (W'(1) << FRAC_BITS) - W'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_MULF, ST_DIV, ST_DIVF, ST_NRCZ, ST_DONE
  } state_t;

  state_t state;
  logic [tle_pkg::PC_W-1:0] pc;
  tle_pkg::tle_instr_t ir;
  logic [W-1:0] opa, opb;

  // Configuration registers
  logic [W-1:0]   fp_re, fp_im, phase, om_re, om_im;
  logic [W-2:0]   eps, esc;
  logic           lav_en;

  // Pixel registers
  logic [W-1:0]   z_re, z_im;
  logic [COUNT_BITS-1:0] lim, cnt;

  // Multiplier and divider
  logic [W-1:0]   ma, mb;
  logic           mneg;
  logic [1:0]     mstep;
  logic [PW-1:0]  acc, den;
  logic [1:0]     nph;
  logic [NW-1:0]  num;
  logic [PW-1:0]  rem;
  logic [W-1:0]   quo;
  logic           qovf;
  logic [DC_W-1:0] dcnt;

  // Working register file
  logic [W-1:0]   rf [16];
  logic           rf_we;
  logic [3:0]     rf_wa;
  logic [W-1:0]   rf_wd;

  tle_pkg::tle_instr_t fi;
  logic [W-1:0]   src_a, src_b;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fp_re <= W'(64'd2147483648);
      fp_im <= '0;
      phase <= '0;
      eps <= (W-1)'(64'd21474836);
      esc <= (W-1)'(64'd429496729600);
      lav_en <= 1'b0;
      om_re <= W'(64'd4294967296);
      om_im <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tle_pkg::CFG_FPRE:  fp_re <= cfg_data;
        tle_pkg::CFG_FPIM:  fp_im <= cfg_data;
        tle_pkg::CFG_PHASE: phase <= cfg_data;
        tle_pkg::CFG_EPS:   eps <= cfg_data[W-2:0];
        tle_pkg::CFG_ESC:   esc <= cfg_data[W-2:0];
        tle_pkg::CFG_EN:    lav_en <= cfg_data[0];
        tle_pkg::CFG_OMRE:  om_re <= cfg_data;
        tle_pkg::CFG_OMIM:  om_im <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand sources: register file below 16, live values from 16 up
  function automatic logic [W-1:0] pick(input logic [4:0] a, input logic [W-1:0] fv,
      input logic [W-1:0] pre, input logic [W-1:0] pim, input logic [W-1:0] ph,
      input logic [W-2:0] ep, input logic [W-2:0] es, input logic [W-1:0] ore,
      input logic [W-1:0] oim, input logic [W-1:0] zr, input logic [W-1:0] zi);
    logic [W-1:0] r;
    r = fv;
    case (a)
      tle_pkg::S_PRE:   r = pre;
      tle_pkg::S_PIM:   r = pim;
      tle_pkg::S_PHASE: r = ph;
      tle_pkg::S_EPS:   r = {1'b0, ep};
      tle_pkg::S_ESC:   r = {1'b0, es};
      tle_pkg::S_OMRE:  r = ore;
      tle_pkg::S_OMIM:  r = oim;
      tle_pkg::S_ZRE:   r = zr;
      tle_pkg::S_ZIM:   r = zi;
      default:          r = fv;
    endcase
    return r;
  endfunction

  assign fi = tle_pkg::rom(pc);
  assign src_a = pick(fi.ra, rf[fi.ra[3:0]], fp_re, fp_im, phase, eps, esc,
                      om_re, om_im, z_re, z_im);
  assign src_b = pick(fi.rb, rf[fi.rb[3:0]], fp_re, fp_im, phase, eps, esc,
                      om_re, om_im, z_re, z_im);

  // Register file: one write port, operands registered at fetch
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (state == ST_FETCH) begin
      opa <= src_a;
      opb <= src_b;
    end
  end

  // Combinational ALU
  logic [W-1:0] alu_res, trc_mag;
  always_comb begin
    trc_mag = tle_pkg::mag(opa) & ~FMASK;
    case (ir.op)
      tle_pkg::OP_ADD: alu_res = tle_pkg::sat49({opa[W-1], opa} + {opb[W-1], opb});
      tle_pkg::OP_SUB: alu_res = tle_pkg::sat49({opa[W-1], opa} - {opb[W-1], opb});
      tle_pkg::OP_DBL: alu_res = tle_pkg::sat49({opa, 1'b0});
      tle_pkg::OP_NEG: alu_res = tle_pkg::sat49(~{opa[W-1], opa} + 1'b1);
      tle_pkg::OP_TRC: alu_res = opa[W-1] ? (~trc_mag + 1'b1) : trc_mag;
      default:         alu_res = opa;
    endcase
  end

  // Partial product of 24-bit halves
  logic [W/2-1:0] ah, bh;
  logic [W-1:0]   pp;
  logic [PW-1:0]  pp_sh, acc_sum, mul_sh;
  logic [W-1:0]   mul_res;
  always_comb begin
    ah = mstep[1] ? ma[W-1:W/2] : ma[W/2-1:0];
    bh = mstep[0] ? mb[W-1:W/2] : mb[W/2-1:0];
    pp = W'(ah) * W'(bh);
    case ({1'b0, mstep[1]} + {1'b0, mstep[0]})
      2'd0:    pp_sh = {{W{1'b0}}, pp};
      2'd1:    pp_sh = {{(W/2){1'b0}}, pp, {(W/2){1'b0}}};
      default: pp_sh = {pp, {W{1'b0}}};
    endcase
    acc_sum = acc + pp_sh;
    mul_sh = acc >> FRAC_BITS;
    mul_res = tle_pkg::from_mag(|mul_sh[PW-1:W], mul_sh[W-1:0], mneg);
  end

  // Restoring division step
  logic [PW:0]  dtrial;
  logic         dge;
  logic [PW:0]  ddiff;
  logic [W-1:0] div_res;
  logic         div_neg;
  always_comb begin
    dtrial = {rem, num[NW-1]};
    ddiff = dtrial - {1'b0, den};
    dge = (dtrial >= {1'b0, den});
    div_neg = (nph == 2'd2) ? (!opa[W-1] && |opa) : opb[W-1];
    div_res = tle_pkg::from_mag(qovf, quo, div_neg);
  end

  // Register file write select
  always_comb begin
    rf_we = 1'b0;
    rf_wa = ir.dst[3:0];
    rf_wd = alu_res;
    unique case (state)
      ST_EXEC: begin
        if (ir.op == tle_pkg::OP_ADD || ir.op == tle_pkg::OP_SUB ||
            ir.op == tle_pkg::OP_DBL || ir.op == tle_pkg::OP_NEG ||
            ir.op == tle_pkg::OP_TRC) begin
          rf_we = 1'b1;
        end else if (ir.op == tle_pkg::OP_NRC && opa == '0 && opb == '0) begin
          rf_we = 1'b1;
          rf_wd = tle_pkg::WMAX;
        end
      end
      ST_MULF: begin
        rf_we = (ir.op == tle_pkg::OP_MUL);
        rf_wd = mul_res;
      end
      ST_DIVF: begin
        rf_we = 1'b1;
        rf_wa = ir.dst[3:0] + {3'b0, nph == 2'd3};
        rf_wd = div_res;
      end
      ST_NRCZ: begin
        rf_we = 1'b1;
        rf_wa = ir.dst[3:0] + 4'd1;
        rf_wd = '0;
      end
      default: ;
    endcase
  end

  // Effective limit: min(iteration_limit, 2^COUNT_BITS - 1)
  logic [31:0] lim32, cmax32, lim_eff;
  assign lim32 = 32'(pixel.data.iteration_limit);
  assign cmax32 = (32'd1 << COUNT_BITS) - 32'd1;
  assign lim_eff = (lim32 > cmax32) ? cmax32 : lim32;

  logic [COUNT_BITS+15:0] cnt_ext;
  assign cnt_ext = {16'b0, cnt};

  assign pixel.ready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= '0;
      cnt <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != ST_DONE) result.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pixel.valid) begin
            z_re <= pixel.data.pixel_re;
            z_im <= pixel.data.pixel_im;
            lim <= lim_eff[COUNT_BITS-1:0];
            cnt <= '0;
            pc <= '0;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          ir <= fi;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          case (ir.op)
            tle_pkg::OP_MUL: begin
              ma <= tle_pkg::mag(opa);
              mb <= tle_pkg::mag(opb);
              mneg <= opa[W-1] ^ opb[W-1];
              acc <= '0;
              mstep <= '0;
              state <= ST_MUL;
            end
            tle_pkg::OP_NRC: begin
              if (opa == '0 && opb == '0) begin
                state <= ST_NRCZ;
              end else begin
                ma <= tle_pkg::mag(opa);
                mb <= tle_pkg::mag(opa);
                acc <= '0;
                mstep <= '0;
                nph <= 2'd0;
                state <= ST_MUL;
              end
            end
            tle_pkg::OP_BLIM: begin
              pc <= (cnt >= lim) ? ir.tgt : pc + 1'b1;
              state <= ST_FETCH;
            end
            tle_pkg::OP_BGE: begin
              pc <= ($signed(opa) >= $signed(opb)) ? ir.tgt : pc + 1'b1;
              state <= ST_FETCH;
            end
            tle_pkg::OP_BDIS: begin
              pc <= (!lav_en) ? ir.tgt : pc + 1'b1;
              state <= ST_FETCH;
            end
            tle_pkg::OP_INC: begin
              cnt <= cnt + 1'b1;
              pc <= ir.tgt;
              state <= ST_FETCH;
            end
            tle_pkg::OP_DONE: begin
              state <= ST_DONE;
            end
            default: begin
              pc <= pc + 1'b1;
              state <= ST_FETCH;
            end
          endcase
        end
        ST_MUL: begin
          acc <= acc_sum;
          mstep <= mstep + 1'b1;
          if (mstep == 2'd3) state <= ST_MULF;
        end
        ST_MULF: begin
          if (ir.op == tle_pkg::OP_MUL) begin
            pc <= pc + 1'b1;
            state <= ST_FETCH;
          end else if (nph == 2'd0) begin
            // hold a^2, then square the imaginary part
            den <= acc;
            ma <= tle_pkg::mag(opb);
            mb <= tle_pkg::mag(opb);
            acc <= '0;
            mstep <= '0;
            nph <= 2'd1;
            state <= ST_MUL;
          end else begin
            den <= den + acc;
            num <= {tle_pkg::mag(opa), {(2 * FRAC_BITS){1'b0}}};
            rem <= '0;
            quo <= '0;
            qovf <= 1'b0;
            dcnt <= '0;
            nph <= 2'd2;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= dge ? ddiff[PW-1:0] : dtrial[PW-1:0];
          num <= {num[NW-2:0], 1'b0};
          quo <= {quo[W-2:0], dge};
          qovf <= qovf | quo[W-1];
          dcnt <= dcnt + 1'b1;
          if (dcnt == DC_W'(NW - 1)) state <= ST_DIVF;
        end
        ST_DIVF: begin
          if (nph == 2'd2) begin
            num <= {tle_pkg::mag(opb), {(2 * FRAC_BITS){1'b0}}};
            rem <= '0;
            quo <= '0;
            qovf <= 1'b0;
            dcnt <= '0;
            nph <= 2'd3;
            state <= ST_DIV;
          end else begin
            pc <= pc + 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_NRCZ: begin
          pc <= pc + 1'b1;
          state <= ST_FETCH;
        end
        ST_DONE: begin
          // wait for the output register to drain
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            result.data.iteration_count <= cnt_ext[15:0];
            result.data.reached_limit <= (cnt >= lim);
            result.data.lower_side <= (cnt < lim) && opa[W-1];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
      (state != ST_IDLE) |-> (cnt <= lim))
    else $error("iteration count passed the limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
      $rose(result.valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the final step");

  a_side_only_on_escape: assert property (@(posedge clk) disable iff (rst)
      result.valid |-> !(result.data.reached_limit && result.data.lower_side))
    else $error("side flag set although the limit was reached");

  a_div_after_squares: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIV) |-> (nph == 2'd2 || nph == 2'd3))
    else $error("divider running outside a reciprocal");
`endif

endmodule

/* test/tb_tricorn_lavaurs_escape_time_core.sv */
`timescale 1ns / 100ps

module tb_tricorn_lavaurs_escape_time_core;

  localparam int FRAC = 32;
  localparam longint QMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QMIN = -QMAX - 1;
  localparam longint QONE = 64'sd1 << FRAC;
  localparam logic [3:0] CFG_UNUSED = 4'd11;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [3:0] cfg_index;
  logic [tle_pkg::W-1:0] cfg_data;

  tle_pixel_if pixel_ch ();
  tle_result_if result_ch ();

  tricorn_lavaurs_escape_time_core DUT (
    .clk(clk),
    .rst(rst),
    .pixel(pixel_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration registers
  longint fp_re, fp_im, phase_q, eps_q, esc_q, rot_re, rot_im;
  bit lav_en;

  tle_pkg::tle_in_t pixel_queue[$];
  tle_pkg::tle_out_t expected_results[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_go;
  logic hold_off;

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- fixed point
  function automatic longint clamp(input longint v);
    return v > QMAX ? QMAX : (v < QMIN ? QMIN : v);
  endfunction

  function automatic longint sext48(input logic [47:0] v);
    logic signed [47:0] s;
    s = v;
    return s;
  endfunction

  function automatic logic [127:0] magn(input longint v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    return {64'b0, m};
  endfunction

  function automatic longint from_wide(input logic [127:0] m, input bit neg);
    if (neg) begin
      if (m > 128'h8000_0000_0000) return QMIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'h7FFF_FFFF_FFFF) return QMAX;
    return longint'(m[63:0]);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    logic [127:0] p;
    p = (magn(a) * magn(b)) >> FRAC;
    return from_wide(p, (a < 0) != (b < 0));
  endfunction

  function automatic cplx_t cmul(input cplx_t a, input cplx_t b);
    cplx_t r;
    r.re = clamp(qmul(a.re, b.re) - qmul(a.im, b.im));
    r.im = clamp(qmul(a.re, b.im) + qmul(a.im, b.re));
    return r;
  endfunction

  function automatic longint norm_sq(input cplx_t a);
    return clamp(qmul(a.re, a.re) + qmul(a.im, a.im));
  endfunction

  // -1/w, saturated; zero maps to the largest positive real
  function automatic cplx_t neg_recip(input cplx_t w);
    cplx_t r;
    logic [127:0] ma, mb, den;
    if (w.re == 0 && w.im == 0) begin
      r.re = QMAX;
      r.im = 0;
      return r;
    end
    ma = magn(w.re);
    mb = magn(w.im);
    den = ma * ma + mb * mb;
    r.re = from_wide((ma << (2 * FRAC)) / den, w.re > 0);
    r.im = from_wide((mb << (2 * FRAC)) / den, w.im < 0);
    return r;
  endfunction

  function automatic cplx_t add_fixed(input cplx_t a);
    cplx_t r;
    r.re = clamp(a.re + fp_re);
    r.im = clamp(a.im + fp_im);
    return r;
  endfunction

  // ------------------------------------------------------------ escape predictor
  function automatic tle_pkg::tle_out_t predict_escape(input tle_pkg::tle_in_t px);
    tle_pkg::tle_out_t o;
    cplx_t p, pp, c, a2, z, x, cx, d, t, w;
    longint eps2, side, tr;
    logic [63:0] tm;
    int unsigned lim, n;
    lim = px.iteration_limit;
    n = 0;
    p.re = fp_re;
    p.im = fp_im;
    pp = cmul(p, p);
    c.re = clamp(p.re - pp.re);
    c.im = clamp(p.im + pp.im);
    a2.re = clamp(clamp(pp.re * 4) + clamp(p.re * 2));
    a2.im = clamp(clamp(pp.im * 4) - clamp(p.im * 2));
    eps2 = qmul(eps_q, eps_q);
    z.re = sext48(px.pixel_re);
    z.im = sext48(px.pixel_im);
    x = add_fixed(neg_recip(cmul(a2, z)));
    while (n < lim && norm_sq(x) < esc_q) begin
      cx.re = x.re;
      cx.im = clamp(-x.im);
      x = cmul(cx, cx);
      x.re = clamp(x.re + c.re);
      x.im = clamp(x.im + c.im);
      if (lav_en) begin
        d.re = clamp(x.re - p.re);
        d.im = clamp(x.im - p.im);
        t = cmul(a2, d);
        t.re = clamp(t.re + eps_q);
        // captured near the fixed point: apply the transit map
        if (norm_sq(t) < eps2) begin
          w = neg_recip(cmul(a2, d));
          tm = magn(w.re);
          tm = tm & ~(QONE - 1);
          tr = w.re < 0 ? -longint'(tm) : longint'(tm);
          w.re = clamp(w.re - 2 * tr + phase_q);
          x = add_fixed(neg_recip(cmul(a2, w)));
        end
      end
      n++;
    end
    o.iteration_count = n[15:0];
    if (n >= lim) begin
      o.reached_limit = 1'b1;
      o.lower_side = 1'b0;
    end else begin
      side = clamp(qmul(rot_re, x.im) + qmul(rot_im, x.re));
      o.reached_limit = 1'b0;
      o.lower_side = side < 0;
    end
    return o;
  endfunction

  function automatic void apply_reg(input logic [3:0] idx,
                                    input logic [tle_pkg::W-1:0] v);
    case (idx)
      tle_pkg::CFG_FPRE:  fp_re = sext48(v);
      tle_pkg::CFG_FPIM:  fp_im = sext48(v);
      tle_pkg::CFG_PHASE: phase_q = sext48(v);
      tle_pkg::CFG_EPS:   eps_q = longint'({17'b0, v[46:0]});
      tle_pkg::CFG_ESC:   esc_q = longint'({17'b0, v[46:0]});
      tle_pkg::CFG_EN:    lav_en = v[0];
      tle_pkg::CFG_OMRE:  rot_re = sext48(v);
      tle_pkg::CFG_OMIM:  rot_im = sext48(v);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  // Predict on each accepted transaction, then offer the next pending pixel
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready)
        expected_results.push_back(predict_escape(pixel_ch.data));
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_ch.valid <= 1'b1;
          pixel_ch.data <= pixel_queue.pop_front();
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- hold-off
  // Hold the receiver off for a long stretch once asked
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    tle_pkg::tle_out_t e;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %p", $time, result_ch.data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result_ch.data.iteration_count !== e.iteration_count) begin
            $display("%0t: iteration_count expected %0d actual %0d", $time,
                     e.iteration_count, result_ch.data.iteration_count);
            errors++;
          end
          if (result_ch.data.reached_limit !== e.reached_limit) begin
            $display("%0t: reached_limit expected %0b actual %0b", $time,
                     e.reached_limit, result_ch.data.reached_limit);
            errors++;
          end
          if (result_ch.data.lower_side !== e.lower_side) begin
            $display("%0t: lower_side expected %0b actual %0b", $time,
                     e.lower_side, result_ch.data.lower_side);
            errors++;
          end
        end
      end
      // hold off while asked, else stall at random
      if (hold_off) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [tle_pkg::W-1:0] rand_coord();
    int k;
    logic [63:0] v;
    logic [tle_pkg::W-1:0] r;
    k = $urandom_range(1, tle_pkg::W);
    v = {$urandom, $urandom};
    r = v[tle_pkg::W-1:0];
    for (int b = 0; b < tle_pkg::W; b++)
      if (b >= k) r[b] = r[k-1];
    return r;
  endfunction

  task automatic add_pixel(input logic [tle_pkg::W-1:0] re,
                           input logic [tle_pkg::W-1:0] im,
                           input logic [15:0] lim);
    tle_pkg::tle_in_t it;
    it.pixel_re = re;
    it.pixel_im = im;
    it.iteration_limit = lim;
    pixel_queue.push_back(it);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [tle_pkg::W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    apply_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pixel_ch.valid || expected_results.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic run_random(input int n, input int lim_hi, input int src, input int snk);
    send_idle_pct = src;
    recv_stall_pct = snk;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        add_pixel(rand_coord(), rand_coord(), 16'($urandom_range(0, 4 * lim_hi)));
      else
        add_pixel(rand_coord(), rand_coord(), 16'($urandom_range(0, lim_hi)));
    end
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tle_pkg::CFG_FPRE;
    cfg_data = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data = '0;
    result_ch.ready = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b0;
    fp_re = 64'sd2147483648;
    fp_im = 0;
    phase_q = 0;
    eps_q = 64'sd21474836;
    esc_q = 64'sd429496729600;
    lav_en = 1'b0;
    rot_re = QONE;
    rot_im = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: defaults, zero divisor, zero limit, extremes of the fields
    add_pixel('0, '0, 16'd5);
    add_pixel(48'd1, 48'd0, 16'hFFFF);
    add_pixel(tle_pkg::WMAX, tle_pkg::WMAX, 16'd0);
    add_pixel(tle_pkg::WMIN, tle_pkg::WMIN, 16'd10);
    add_pixel(48'h1_0000_0000, '0, 16'd20);
    add_pixel(48'hFFFF_0000_0000, 48'h1_0000_0000, 16'd20);
    add_pixel('0, 48'd1, 16'hAAAA);
    add_pixel(48'd1, '0, 16'h5555);
    add_pixel(48'h1000_0000, 48'hFFFF_F000_0000, 16'd30);
    add_pixel(tle_pkg::WMIN, tle_pkg::WMAX, 16'd3);
    add_pixel(48'h8000_0000, 48'h8000_0000, 16'd40);
    wait_drained();

    // Lavaurs map always capturing; stray bits above register widths
    write_reg(tle_pkg::CFG_EN, 48'hFFFF_FFFF_FFFE | 48'd1);
    write_reg(tle_pkg::CFG_EPS, 48'h8100_0000_0000);
    write_reg(tle_pkg::CFG_PHASE, 48'h3_B000_0000);
    write_reg(tle_pkg::CFG_OMRE, '0);
    write_reg(tle_pkg::CFG_OMIM, 48'h1_0000_0000);
    write_reg(CFG_UNUSED, tle_pkg::WMAX);
    add_pixel(48'h4000_0000, 48'h2000_0000, 16'd3);
    add_pixel(48'hFFFF_C000_0000, 48'h1000_0000, 16'd4);
    add_pixel(48'h2_0000_0000, 48'hFFFE_0000_0000, 16'd2);
    add_pixel('0, '0, 16'd2);
    wait_drained();
    run_random(20, 5, 0, 0);

    // Extremes of every register but the enable
    write_reg(tle_pkg::CFG_FPRE, tle_pkg::WMAX);
    write_reg(tle_pkg::CFG_FPIM, tle_pkg::WMIN);
    write_reg(tle_pkg::CFG_PHASE, tle_pkg::WMIN);
    write_reg(tle_pkg::CFG_EPS, '0);
    write_reg(tle_pkg::CFG_ESC, 48'h7FFF_FFFF_FFFF);
    write_reg(tle_pkg::CFG_OMRE, tle_pkg::WMIN);
    write_reg(tle_pkg::CFG_OMIM, tle_pkg::WMAX);
    run_random(20, 10, 80, 0);

    write_reg(tle_pkg::CFG_FPRE, tle_pkg::WMIN);
    write_reg(tle_pkg::CFG_FPIM, tle_pkg::WMAX);
    write_reg(tle_pkg::CFG_PHASE, tle_pkg::WMAX);
    write_reg(tle_pkg::CFG_EPS, 48'h7FFF_FFFF_FFFF);
    write_reg(tle_pkg::CFG_ESC, '0);
    run_random(10, 10, 20, 20);

    // Moderate point with a real capture radius; long receiver hold-off
    write_reg(tle_pkg::CFG_FPRE, 48'h4000_0000);
    write_reg(tle_pkg::CFG_FPIM, 48'h1999_9999);
    write_reg(tle_pkg::CFG_PHASE, rand_coord());
    write_reg(tle_pkg::CFG_EPS, 48'h2000_0000);
    write_reg(tle_pkg::CFG_ESC, 48'h4_0000_0000);
    write_reg(tle_pkg::CFG_OMRE, rand_coord());
    write_reg(tle_pkg::CFG_OMIM, rand_coord());
    hold_go = 1'b1;
    run_random(30, 12, 0, 0);
    run_random(20, 12, 0, 80);

    // Back to a plain tricorn with random rotation
    write_reg(tle_pkg::CFG_EN, '0);
    write_reg(tle_pkg::CFG_FPRE, 48'h8000_0000);
    write_reg(tle_pkg::CFG_FPIM, '0);
    write_reg(tle_pkg::CFG_ESC, 48'h64_0000_0000);
    run_random(25, 12, 20, 20);
    run_random(25, 12, 0, 0);

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_tricorn_lavaurs_escape_time_core: PASS");
    end else begin
      $display("tb_tricorn_lavaurs_escape_time_core: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("tb_tricorn_lavaurs_escape_time_core: FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/tle_pkg.sv
src/tle_if.sv
src/tricorn_lavaurs_escape_time_core.sv
test/tb_tricorn_lavaurs_escape_time_core.sv
